>>> rtl/value_count_tree_order_statistics_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the value count tree order statistics block
// Concurrent assertion wrappers that compile away under NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef VALUE_COUNT_TREE_ORDER_STATISTICS_DEFINES_SVH
`define VALUE_COUNT_TREE_ORDER_STATISTICS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define VCTOS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define VCTOS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define VCTOS_ASSERT(lbl, clk, rst, prop, msg)
`define VCTOS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/vctos_pkg.sv
// ----------------------------------------------------------------------------
// vctos_pkg
// Types, codes and constants shared by the order statistics tree block.
// ----------------------------------------------------------------------------
`default_nettype none
package vctos_pkg;

   localparam int VALUE_RANGE_DEFAULT = 1024;
   localparam logic [10:0] DOMAIN_RESET = 11'd1024;
   localparam logic [62:0] INV_MAX = {63{1'b1}};
   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   localparam logic [2:0] MODE_INSERT  = 3'd0;
   localparam logic [2:0] MODE_COUNT   = 3'd1;
   localparam logic [2:0] MODE_RANGE   = 3'd2;
   localparam logic [2:0] MODE_KTH_MIN = 3'd3;
   localparam logic [2:0] MODE_KTH_MAX = 3'd4;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_DOMAIN = 2'd1;
   localparam logic [1:0] STATUS_RANK   = 2'd2;
   localparam logic [1:0] STATUS_SAT    = 2'd3;

   typedef struct packed {
      logic [2:0]  mode;
      logic [10:0] value;
      logic [10:0] range_high;
      logic [31:0] rank;
   } req_type;

   typedef struct packed {
      logic [31:0] answer;
      logic [62:0] inversion_total;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_LO_READ,
      ST_LO_EVAL,
      ST_READ,
      ST_EVAL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic accept;
      logic start_lo;
      logic start_main;
      logic eval;
      logic lo_pass;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic need_descent;
      logic lo_first;
      logic is_leaf;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

>>> rtl/vctos_ctrl.sv
// ----------------------------------------------------------------------------
// vctos_ctrl
// Sequencer for the clearing sweep, tree descents and result transfer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "value_count_tree_order_statistics_defines.svh"
module vctos_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire vctos_pkg::stat_type stat,
   output vctos_pkg::cmd_type      cmd
);

   vctos_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vctos_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vctos_pkg::ST_CLEAR: begin
            if (stat.clear_done) state_in = vctos_pkg::ST_IDLE;
         end
         vctos_pkg::ST_IDLE: begin
            if (req_valid) state_in = vctos_pkg::ST_START;
         end
         vctos_pkg::ST_START: begin
            if (!stat.need_descent) state_in = vctos_pkg::ST_FINISH;
            else if (stat.lo_first) state_in = vctos_pkg::ST_LO_READ;
            else state_in = vctos_pkg::ST_READ;
         end
         vctos_pkg::ST_LO_READ: state_in = vctos_pkg::ST_LO_EVAL;
         vctos_pkg::ST_LO_EVAL: begin
            state_in = stat.is_leaf ? vctos_pkg::ST_READ : vctos_pkg::ST_LO_READ;
         end
         vctos_pkg::ST_READ: state_in = vctos_pkg::ST_EVAL;
         vctos_pkg::ST_EVAL: begin
            state_in = stat.is_leaf ? vctos_pkg::ST_FINISH : vctos_pkg::ST_READ;
         end
         vctos_pkg::ST_FINISH: begin
            if (stat.out_free) state_in = vctos_pkg::ST_IDLE;
         end
         default: state_in = vctos_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         vctos_pkg::ST_CLEAR: cmd.clear_step = !stat.clear_done;
         vctos_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.accept = req_valid;
         end
         vctos_pkg::ST_START: begin
            cmd.start_lo = stat.need_descent && stat.lo_first;
            cmd.start_main = stat.need_descent && !stat.lo_first;
         end
         vctos_pkg::ST_LO_EVAL: begin
            cmd.eval = 1'b1;
            cmd.lo_pass = 1'b1;
            cmd.start_main = stat.is_leaf;
         end
         vctos_pkg::ST_EVAL: cmd.eval = 1'b1;
         vctos_pkg::ST_FINISH: cmd.finish = stat.out_free;
         default: cmd = '0;
      endcase
   end

   `VCTOS_ASSERT(a_finish_free, clock, reset, cmd.finish |-> stat.out_free,
      "Result loaded while previous result pending")
   `VCTOS_ASSERT(a_accept_cleared, clock, reset, cmd.accept |-> stat.clear_done,
      "Item accepted before clearing sweep finished")
   `VCTOS_ASSERT_NEXT(a_start_descends, clock, reset, cmd.start_main && !cmd.eval,
      state_ff == vctos_pkg::ST_READ, "Main descent did not begin")

endmodule
`default_nettype wire

>>> rtl/vctos_dp.sv
// ----------------------------------------------------------------------------
// vctos_dp
// Count tree memory, descent registers, running totals and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "value_count_tree_order_statistics_defines.svh"
module vctos_dp #(
   parameter int VALUE_RANGE = vctos_pkg::VALUE_RANGE_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire vctos_pkg::cmd_type cmd,
   output vctos_pkg::stat_type     stat,
   input  wire vctos_pkg::req_type req_payload,
   input  wire logic               csr_write,
   input  wire logic [10:0]        csr_wdata,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output vctos_pkg::rsp_type      rsp_payload
);

   localparam int NODE_SLOTS = 4 * VALUE_RANGE;
   localparam int AW = $clog2(NODE_SLOTS);
   localparam int VW = $clog2(VALUE_RANGE + 1);
   localparam int CW = (VW > 11) ? VW : 11;

   logic [31:0] mem [NODE_SLOTS];

   logic [10:0]   dom_ff;
   logic [AW:0]   clr_ff;
   logic [2:0]    mode_ff;
   logic [1:0]    err_ff;
   logic          need_ff, lo_first_ff, hi_le_ff;
   logic [VW-1:0] lo_ff, hi_ff, x_ff, l_ff, r_ff, sel_ff;
   logic [31:0]   k_ff, acc_ff, save_ff, leaf_ff, rd_a_ff, rd_b_ff, total_ff;
   logic [AW-1:0] node_ff;
   logic [62:0]   inv_ff;
   logic          rsp_valid_ff;
   vctos_pkg::rsp_type rsp_ff;

   logic [CW-1:0] dom_c, v_c, h_c;
   logic          v_ok, h_ok, sel_mode, largest;
   logic [1:0]    err_c;
   logic          need_c;
   logic [VW-1:0] mid, x_start;
   logic [AW-1:0] addr_a, addr_b;
   logic          go_right, is_leaf, wr_en;
   logic [31:0]   acc_in, k_in, greater;
   logic [63:0]   inv_sum;
   vctos_pkg::rsp_type rsp_in;

   always_comb begin
      dom_c = CW'(dom_ff);
      if (dom_c == '0) dom_c = CW'(1);
      if (dom_c > CW'(VALUE_RANGE)) dom_c = CW'(VALUE_RANGE);
      v_c = CW'(req_payload.value);
      h_c = CW'(req_payload.range_high);
      v_ok = (v_c != '0) && (v_c <= dom_c);
      h_ok = (h_c != '0) && (h_c <= dom_c);
      err_c = vctos_pkg::STATUS_OK;
      need_c = 1'b0;
      case (req_payload.mode)
         vctos_pkg::MODE_INSERT: begin
            if (!v_ok) err_c = vctos_pkg::STATUS_DOMAIN;
            else if (total_ff == vctos_pkg::COUNT_MAX) err_c = vctos_pkg::STATUS_SAT;
            need_c = (err_c == vctos_pkg::STATUS_OK);
         end
         vctos_pkg::MODE_COUNT: begin
            if (!v_ok) err_c = vctos_pkg::STATUS_DOMAIN;
            need_c = v_ok;
         end
         vctos_pkg::MODE_RANGE: begin
            if (!v_ok || !h_ok) err_c = vctos_pkg::STATUS_DOMAIN;
            need_c = v_ok && h_ok && (v_c <= h_c);
         end
         vctos_pkg::MODE_KTH_MIN, vctos_pkg::MODE_KTH_MAX: begin
            if (req_payload.rank == '0 || req_payload.rank > total_ff) begin
               err_c = vctos_pkg::STATUS_RANK;
            end
            need_c = (err_c == vctos_pkg::STATUS_OK);
         end
         default: begin
            err_c = vctos_pkg::STATUS_OK;
            need_c = 1'b0;
         end
      endcase
   end

   assign sel_mode = (mode_ff == vctos_pkg::MODE_KTH_MIN) ||
                     (mode_ff == vctos_pkg::MODE_KTH_MAX);
   assign largest = (mode_ff == vctos_pkg::MODE_KTH_MAX);
   assign is_leaf = (l_ff == r_ff);
   assign mid = l_ff + ((r_ff - l_ff) >> 1);
   assign addr_a = sel_mode ? AW'({node_ff, 1'b1}) : node_ff;
   assign addr_b = AW'({node_ff, 1'b0});
   assign wr_en = cmd.eval && !cmd.lo_pass && (mode_ff == vctos_pkg::MODE_INSERT);
   assign x_start = cmd.start_lo ? (lo_ff - VW'(1)) :
                    ((mode_ff == vctos_pkg::MODE_RANGE) ? hi_ff : lo_ff);

   always_comb begin
      acc_in = acc_ff;
      k_in = k_ff;
      if (sel_mode) begin
         if (largest) begin
            go_right = (k_ff <= rd_a_ff);
            if (!go_right) k_in = k_ff - rd_a_ff;
         end else begin
            go_right = (k_ff > rd_b_ff);
            if (go_right) k_in = k_ff - rd_b_ff;
         end
      end else begin
         go_right = (x_ff > mid);
         if (is_leaf) acc_in = acc_ff + rd_a_ff;
         else if (go_right) acc_in = acc_ff + rd_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem[addr_a];
      rd_b_ff <= mem[addr_b];
      if (cmd.clear_step) begin
         mem[clr_ff[AW-1:0]] <= '0;
      end else if (wr_en) begin
         mem[node_ff] <= rd_a_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         dom_ff <= vctos_pkg::DOMAIN_RESET;
         total_ff <= '0;
         inv_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + (AW+1)'(1);
         if (csr_write) dom_ff <= csr_wdata;
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.finish && mode_ff == vctos_pkg::MODE_INSERT &&
             err_ff == vctos_pkg::STATUS_OK) begin
            total_ff <= total_ff + 32'd1;
            inv_ff <= inv_sum[63] ? vctos_pkg::INV_MAX : inv_sum[62:0];
         end
      end
   end

   assign greater = total_ff - acc_ff;
   assign inv_sum = {1'b0, inv_ff} + {32'd0, greater};

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_payload.mode;
         err_ff <= err_c;
         need_ff <= need_c;
         lo_first_ff <= (req_payload.mode == vctos_pkg::MODE_RANGE) && (v_c > CW'(1));
         hi_le_ff <= (v_c <= h_c);
         lo_ff <= VW'(v_c);
         hi_ff <= VW'(h_c);
         k_ff <= req_payload.rank;
         save_ff <= '0;
      end else begin
         if (cmd.eval && cmd.lo_pass && is_leaf) save_ff <= acc_in;
         if (cmd.eval && !cmd.lo_pass && is_leaf) begin
            leaf_ff <= rd_a_ff;
            sel_ff <= l_ff;
         end
         if (cmd.start_lo || cmd.start_main) begin
            node_ff <= AW'(1);
            l_ff <= VW'(1);
            r_ff <= VW'(VALUE_RANGE);
            acc_ff <= '0;
            x_ff <= x_start;
         end else if (cmd.eval && !is_leaf) begin
            acc_ff <= acc_in;
            k_ff <= k_in;
            if (go_right) begin
               node_ff <= AW'({node_ff, 1'b1});
               l_ff <= mid + VW'(1);
            end else begin
               node_ff <= AW'({node_ff, 1'b0});
               r_ff <= mid;
            end
         end else if (cmd.eval) begin
            acc_ff <= acc_in;
         end
      end
   end

   always_comb begin
      rsp_in.status = err_ff;
      rsp_in.answer = '0;
      rsp_in.inversion_total = inv_ff;
      if (err_ff == vctos_pkg::STATUS_OK) begin
         case (mode_ff)
            vctos_pkg::MODE_INSERT: begin
               rsp_in.answer = greater;
               if (inv_sum[63]) begin
                  rsp_in.inversion_total = vctos_pkg::INV_MAX;
                  rsp_in.status = vctos_pkg::STATUS_SAT;
               end else begin
                  rsp_in.inversion_total = inv_sum[62:0];
               end
            end
            vctos_pkg::MODE_COUNT: rsp_in.answer = leaf_ff;
            vctos_pkg::MODE_RANGE: begin
               rsp_in.answer = hi_le_ff ? (acc_ff - save_ff) : '0;
            end
            vctos_pkg::MODE_KTH_MIN, vctos_pkg::MODE_KTH_MAX: begin
               rsp_in.answer = 32'(sel_ff);
            end
            default: rsp_in.answer = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) rsp_ff <= rsp_in;
   end

   assign stat.clear_done = (clr_ff == (AW+1)'(NODE_SLOTS));
   assign stat.need_descent = need_ff;
   assign stat.lo_first = lo_first_ff;
   assign stat.is_leaf = is_leaf;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `VCTOS_ASSERT_NEXT(a_descend_down, clock, reset,
      cmd.eval && !is_leaf && !cmd.start_main, node_ff > $past(node_ff),
      "Descent did not move to a child node")
   `VCTOS_ASSERT(a_no_write_in_clear, clock, reset, cmd.clear_step |-> !wr_en,
      "Tree update during clearing sweep")
   `VCTOS_ASSERT(a_leaf_bounds, clock, reset, cmd.eval |-> (l_ff <= r_ff),
      "Descent interval became empty")

endmodule
`default_nettype wire

>>> rtl/value_count_tree_order_statistics.sv
// ----------------------------------------------------------------------------
// value_count_tree_order_statistics
// Order statistics over a multiset of values kept as a tree of counts.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ channel (mode, value, range_high, rank) and each
// produces exactly one response on the rsp_ channel (answer, running inversion
// total, status). The csr_ channel writes the domain size; it is always ready.
// After reset the tree memory of 4*VALUE_RANGE entries is cleared, one entry
// per cycle, while req_ready stays low.
// One request is processed at a time. A tree descent spends a read step and an
// evaluate step on each level, as the count memory is read through a register;
// the tree has 11 levels at the default. A range count with a low end above one
// makes an extra descent first, for the count below its low end, and requests
// that fail their checks skip the descent. A new request is accepted while a
// finished response still waits; if the receiver stalls, the next response waits
// in its finishing step until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none
module value_count_tree_order_statistics #(
   parameter int VALUE_RANGE = vctos_pkg::VALUE_RANGE_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire vctos_pkg::req_type req_payload,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output vctos_pkg::rsp_type      rsp_payload,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [10:0]        csr_wdata
);

   vctos_pkg::cmd_type  cmd;
   vctos_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   vctos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   vctos_dp #(
      .VALUE_RANGE (VALUE_RANGE)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_wdata   (csr_wdata),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

>>> dv/value_count_tree_order_statistics_tb.sv
// ----------------------------------------------------------------------------
// Testbench for value_count_tree_order_statistics
// Drives insert, count, range count and k-th selection requests with random
// gaps and response stalls across several domain sizes, predicts each
// response from a per-value count table and checks every field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class order_stat_scoreboard;
   int unsigned           value_counts [1:1024];
   logic [31:0]           held_total;
   logic [62:0]           inversion_acc;
   logic [10:0]           domain_reg;
   vctos_pkg::rsp_type    expected_rsps [$];
   int                    errors;

   function new();
      for (int v = 1; v <= 1024; v++) value_counts[v] = 0;
      held_total = '0;
      inversion_acc = '0;
      domain_reg = vctos_pkg::DOMAIN_RESET;
      errors = 0;
   endfunction

   function int unsigned active_domain();
      if (domain_reg < 1) return 1;
      if (domain_reg > 1024) return 1024;
      return domain_reg;
   endfunction

   function void note_request(vctos_pkg::req_type r);
      vctos_pkg::rsp_type e;
      int unsigned        dom;
      logic [63:0]        acc;
      logic [31:0]        k;
      bit                 in_dom;
      dom = active_domain();
      e = '0;
      e.status = vctos_pkg::STATUS_OK;
      in_dom = (r.value >= 1) && (r.value <= dom);
      acc = '0;
      case (r.mode)
         vctos_pkg::MODE_INSERT: begin
            if (!in_dom) begin
               e.status = vctos_pkg::STATUS_DOMAIN;
            end else if (held_total == vctos_pkg::COUNT_MAX) begin
               e.status = vctos_pkg::STATUS_SAT;
            end else begin
               for (int v = r.value + 1; v <= 1024; v++) acc += value_counts[v];
               e.answer = acc[31:0];
               if (acc > ({1'b0, vctos_pkg::INV_MAX} - {1'b0, inversion_acc})) begin
                  inversion_acc = vctos_pkg::INV_MAX;
                  e.status = vctos_pkg::STATUS_SAT;
               end else begin
                  inversion_acc = inversion_acc + acc[62:0];
               end
               value_counts[r.value]++;
               held_total++;
            end
         end
         vctos_pkg::MODE_COUNT: begin
            if (!in_dom) e.status = vctos_pkg::STATUS_DOMAIN;
            else e.answer = value_counts[r.value];
         end
         vctos_pkg::MODE_RANGE: begin
            if (!in_dom || r.range_high < 1 || r.range_high > dom) begin
               e.status = vctos_pkg::STATUS_DOMAIN;
            end else begin
               for (int v = r.value; v <= r.range_high; v++) acc += value_counts[v];
               e.answer = acc[31:0];
            end
         end
         vctos_pkg::MODE_KTH_MIN, vctos_pkg::MODE_KTH_MAX: begin
            if (r.rank == 0 || r.rank > held_total) begin
               e.status = vctos_pkg::STATUS_RANK;
            end else begin
               k = r.rank;
               if (r.mode == vctos_pkg::MODE_KTH_MIN) begin
                  for (int v = 1; v <= 1024; v++) begin
                     if (e.answer == 0 && k <= value_counts[v]) e.answer = v;
                     else if (e.answer == 0) k -= value_counts[v];
                  end
               end else begin
                  for (int v = 1024; v >= 1; v--) begin
                     if (e.answer == 0 && k <= value_counts[v]) e.answer = v;
                     else if (e.answer == 0) k -= value_counts[v];
                  end
               end
            end
         end
         default: ;
      endcase
      e.inversion_total = inversion_acc;
      expected_rsps.push_back(e);
   endfunction

   function void check_response(vctos_pkg::rsp_type got);
      vctos_pkg::rsp_type e;
      if (expected_rsps.size() == 0) begin
         $display("%0t: unexpected response answer=%0d total=%0d status=%0d",
                  $time, got.answer, got.inversion_total, got.status);
         errors++;
         return;
      end
      e = expected_rsps.pop_front();
      if (got.answer !== e.answer) begin
         $display("%0t: answer expected %0d actual %0d", $time, e.answer, got.answer);
         errors++;
      end
      if (got.inversion_total !== e.inversion_total) begin
         $display("%0t: inversion_total expected %0d actual %0d", $time,
                  e.inversion_total, got.inversion_total);
         errors++;
      end
      if (got.status !== e.status) begin
         $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
         errors++;
      end
   endfunction
endclass

module value_count_tree_order_statistics_tb;

   localparam int IDLE_LIMIT = 20000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   vctos_pkg::req_type  req_payload;
   logic                rsp_valid;
   logic                rsp_ready;
   vctos_pkg::rsp_type  rsp_payload;
   logic                csr_valid;
   logic                csr_ready;
   logic [10:0]         csr_wdata;

   order_stat_scoreboard scoreboard;
   int          idle_cycles;
   bit          stall_free;

   value_count_tree_order_statistics u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
         if (req_valid && req_ready) scoreboard.note_request(req_payload);
         if (rsp_valid && rsp_ready) scoreboard.check_response(rsp_payload);
      end
   end

   always @(posedge clock) begin
      if (stall_free) rsp_ready <= 1'b1;
      else if ($urandom_range(0, 99) < 3) rsp_ready <= 1'b0;
      else if (!rsp_ready && $urandom_range(0, 99) < 30) rsp_ready <= 1'b1;
      else if ($urandom_range(0, 99) < 15) rsp_ready <= 1'b0;
      else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_free <= ~stall_free;
   end

   task automatic send_request(vctos_pkg::req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (scoreboard.expected_rsps.size() > 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_domain(logic [10:0] size);
      csr_valid <= 1'b1;
      csr_wdata <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      scoreboard.domain_reg = size;
   endtask

   task automatic send_fields(logic [2:0] mode, logic [10:0] value, logic [10:0] high,
                              logic [31:0] rank);
      vctos_pkg::req_type r;
      r.mode = mode;
      r.value = value;
      r.range_high = high;
      r.rank = rank;
      send_request(r);
   endtask

   function automatic logic [10:0] pick_value(int unsigned dom);
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, dom);
      return $urandom_range(0, 2047);
   endfunction

   task automatic random_request(int unsigned dom);
      vctos_pkg::req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      r.value = pick_value(dom);
      r.range_high = pick_value(dom);
      r.rank = $urandom();
      if (roll < 40) r.mode = vctos_pkg::MODE_INSERT;
      else if (roll < 50) r.mode = vctos_pkg::MODE_COUNT;
      else if (roll < 65) r.mode = vctos_pkg::MODE_RANGE;
      else if (roll < 80) r.mode = vctos_pkg::MODE_KTH_MIN;
      else if (roll < 95) r.mode = vctos_pkg::MODE_KTH_MAX;
      else r.mode = 3'($urandom_range(5, 7));
      if (r.mode == vctos_pkg::MODE_RANGE && r.range_high < r.value &&
          $urandom_range(0, 3) != 0)
         {r.value, r.range_high} = {r.range_high, r.value};
      if ((r.mode == vctos_pkg::MODE_KTH_MIN || r.mode == vctos_pkg::MODE_KTH_MAX) &&
          $urandom_range(0, 9) != 0 && scoreboard.held_total > 0)
         r.rank = $urandom_range(1, scoreboard.held_total);
      send_request(r);
   endtask

   initial begin
      logic [10:0] settings [6];
      scoreboard = new();
      settings = '{11'd1, 11'd2047, 11'd0, 11'd16, 11'd300, 11'd1024};
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b1;
      csr_valid = 1'b0;
      csr_wdata = '0;
      stall_free = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_fields(vctos_pkg::MODE_KTH_MIN, 11'd1, 11'd1, 32'd1);
      send_fields(vctos_pkg::MODE_KTH_MAX, 11'd1, 11'd1, 32'd0);
      send_fields(vctos_pkg::MODE_INSERT, 11'd1024, 11'd0, 32'hFFFF_FFFF);
      send_fields(vctos_pkg::MODE_INSERT, 11'd1, 11'd2047, 32'd0);
      send_fields(vctos_pkg::MODE_INSERT, 11'd512, 11'd0, 32'd0);
      send_fields(vctos_pkg::MODE_INSERT, 11'd1, 11'd0, 32'd0);
      send_fields(vctos_pkg::MODE_INSERT, 11'd0, 11'd0, 32'd0);
      send_fields(vctos_pkg::MODE_INSERT, 11'd1025, 11'd0, 32'd0);
      send_fields(vctos_pkg::MODE_INSERT, 11'd2047, 11'd0, 32'd0);
      send_fields(vctos_pkg::MODE_COUNT, 11'd1, 11'd0, 32'd0);
      send_fields(vctos_pkg::MODE_COUNT, 11'd1024, 11'd0, 32'd0);
      send_fields(vctos_pkg::MODE_COUNT, 11'd0, 11'd0, 32'd0);
      send_fields(vctos_pkg::MODE_RANGE, 11'd1, 11'd1024, 32'd0);
      send_fields(vctos_pkg::MODE_RANGE, 11'd600, 11'd2, 32'd0);
      send_fields(vctos_pkg::MODE_RANGE, 11'd2, 11'd0, 32'd0);
      send_fields(vctos_pkg::MODE_RANGE, 11'd2, 11'd1025, 32'd0);
      send_fields(vctos_pkg::MODE_KTH_MIN, 11'd0, 11'd0, 32'd1);
      send_fields(vctos_pkg::MODE_KTH_MIN, 11'd0, 11'd0, 32'd4);
      send_fields(vctos_pkg::MODE_KTH_MAX, 11'd0, 11'd0, 32'd1);
      send_fields(vctos_pkg::MODE_KTH_MAX, 11'd0, 11'd0, 32'd4);
      send_fields(vctos_pkg::MODE_KTH_MAX, 11'd0, 11'd0, 32'd5);
      send_fields(3'd5, 11'd3, 11'd3, 32'd1);
      send_fields(3'd6, 11'd2047, 11'd2047, 32'hFFFF_FFFF);
      send_fields(3'd7, 11'd0, 11'd0, 32'd0);
      drain();

      foreach (settings[i]) begin
         write_domain(settings[i]);
         repeat (60) random_request(scoreboard.active_domain());
         drain();
         write_domain(11'($urandom_range(0, 2047)));
         repeat (50) random_request(scoreboard.active_domain());
         drain();
      end

      if (scoreboard.errors == 0 && scoreboard.expected_rsps.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
